[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the RTL; empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

[hdl/grd_pkg.sv]
// ----------------------------------------------------------------------------
// Genotype record decoder package
// Field widths, stream data widths, mode and error codes.
// ----------------------------------------------------------------------------
package grd_pkg;

    // Largest record length that the design supports.
    localparam int unsigned MAX_SAMPLES  = 65536;
    localparam int unsigned LEN_W        = 17;
    localparam int unsigned POS_W        = 16;
    localparam int unsigned RECORD_CAP   = (MAX_SAMPLES < 65536) ? MAX_SAMPLES : 65536;

    localparam int unsigned MODE_W       = 2;
    localparam int unsigned GENO_W       = 2;
    localparam int unsigned DOSAGE_W     = 16;
    localparam int unsigned DCOUNT_W     = 17;
    localparam int unsigned ERR_W        = 3;
    localparam int unsigned CFG_ADDR_W   = 1;
    localparam int unsigned CFG_DATA_W   = 17;

    localparam int unsigned S_TDATA_W    = 40;
    localparam int unsigned M_TDATA_W    = 40;

    localparam int unsigned DOSAGE_ONE_SHIFT = 14;
    localparam logic [DOSAGE_W-1:0] DOSAGE_MAX = 16'd32768;
    localparam logic [DOSAGE_W-1:0] DOSAGE_NA  = 16'hFFFF;

    typedef enum logic [GENO_W-1:0] {
        GENO_HOM_REF = 2'd0,
        GENO_HET     = 2'd1,
        GENO_HOM_ALT = 2'd2,
        GENO_NA      = 2'd3
    } geno_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_HARDCALL   = 2'd0,
        MODE_DOSAGE     = 2'd1,
        MODE_HAPLOTYPE  = 2'd2,
        MODE_DOSAGE_F64 = 2'd3
    } mode_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 3'd0,
        ERR_OVER     = 3'd1,
        ERR_BITMAP   = 3'd2,
        ERR_VALUES   = 3'd3,
        ERR_MISSING  = 3'd4,
        ERR_UNPHASED = 3'd5
    } err_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MODE         = 1'd0,
        REG_SAMPLE_COUNT = 1'd1
    } cfg_reg_t;

    // One input item, unpacked from the slave tdata.
    typedef struct packed {
        logic [GENO_W-1:0]   geno;
        logic                dosage_given;
        logic [DOSAGE_W-1:0] dosage_value;
        logic [DCOUNT_W-1:0] dosage_count;
        logic                phase_carried;
        logic                phase_present;
        logic                phase_info;
    } in_item_t;

    // One result item before packing into the master tdata.
    typedef struct packed {
        logic [POS_W-1:0]    sample_index;
        logic [1:0]          call;
        logic [DOSAGE_W-1:0] dosage_q14;
        logic                hap_first;
        logic                hap_second;
        logic                missing;
        logic [ERR_W-1:0]    error_code;
        logic                last_in_record;
    } out_item_t;

endpackage

[hdl/genotype_record_decoder.sv]
// ----------------------------------------------------------------------------
// Genotype record decoder
// Decodes one sample of a genotype record per item into a call, a Q2.14
// dosage or a haplotype pair, with per-record error tracking.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the s_axis stream, one per item, in record order. Each
// item yields exactly one result on the m_axis stream; m_axis_tlast marks the
// final sample of a record (record length taken from sample_count).
// The cfg port writes the mode and sample_count registers; write them only
// while no item is in flight.
// From input handshake to m_axis_tvalid an item passes an input
// register, then the decode logic feeding the result register. Throughput is
// one item per cycle while the receiver takes results, set by the single
// decode stage and the running counters that it updates for every sample.
// When the receiver stalls, the result register holds and the input
// register still takes one more item; s_axis_tready then drops until the
// result is taken.
// Reset clears both pipeline valid flags, the sample and dosage counters and
// the latched record error; mode returns to hardcall, sample_count to one.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module genotype_record_decoder #(
    parameter int unsigned MAX_SAMPLES = grd_pkg::MAX_SAMPLES
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // cfg: register 0 mode, register 1 sample_count
    input  logic                               cfg_we,
    input  logic [grd_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [grd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: geno[1:0], dosage_given[2], dosage_value[18:3],
    // dosage_count[35:19], phase_carried[36], phase_present[37],
    // phase_info[38], zero pad[39]
    input  logic [grd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0: sample_index[15:0], call[17:16], dosage_q14[33:18],
    // hap_first[34], hap_second[35], missing[36], error_code[39:37]
    output logic [grd_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    output logic                               m_axis_tlast
);
    import grd_pkg::*;

    localparam int unsigned LEN_CAP = (MAX_SAMPLES < RECORD_CAP) ? MAX_SAMPLES : RECORD_CAP;

    // Configuration registers
    mode_t              mode_reg;
    logic [LEN_W-1:0]   count_reg;

    // Input register
    logic               in_valid_reg, in_valid_next;
    in_item_t           in_item_reg;
    in_item_t           s_item;

    // Record state
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [DCOUNT_W-1:0] used_reg, used_next;
    err_t                rec_err_reg, rec_err_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_item_reg, res;

    logic               advance;
    logic               s_accept;
    logic               step;
    logic [LEN_W-1:0]   rec_len;
    logic [LEN_W-1:0]   pos_plus1;
    logic               last;
    err_t               err;

    assign s_item.geno           = s_axis_tdata[1:0];
    assign s_item.dosage_given   = s_axis_tdata[2];
    assign s_item.dosage_value   = s_axis_tdata[18:3];
    assign s_item.dosage_count   = s_axis_tdata[35:19];
    assign s_item.phase_carried  = s_axis_tdata[36];
    assign s_item.phase_present  = s_axis_tdata[37];
    assign s_item.phase_info     = s_axis_tdata[38];

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign step          = in_valid_reg && advance;

    // A zero length counts as one; lengths above the cap saturate.
    always_comb begin
        if (count_reg == '0) begin
            rec_len = LEN_W'(1);
        end else if (count_reg > LEN_W'(LEN_CAP)) begin
            rec_len = LEN_W'(LEN_CAP);
        end else begin
            rec_len = count_reg;
        end
    end

    assign pos_plus1 = {1'b0, pos_reg} + LEN_W'(1);
    assign last      = pos_plus1 >= rec_len;

    always_comb begin
        err       = rec_err_reg;
        used_next = used_reg;
        res       = '0;
        res.sample_index   = pos_reg;
        res.last_in_record = last;

        if (rec_err_reg == ERR_NONE) begin
            case (mode_reg)
                MODE_HARDCALL: begin
                    if (in_item_reg.geno == GENO_NA) begin
                        res.missing = 1'b1;
                    end else begin
                        res.call = in_item_reg.geno;
                    end
                end
                MODE_HAPLOTYPE: begin
                    case (geno_t'(in_item_reg.geno))
                        GENO_NA: begin
                            err = ERR_MISSING;
                        end
                        GENO_HOM_ALT: begin
                            res.hap_first  = 1'b1;
                            res.hap_second = 1'b1;
                        end
                        GENO_HET: begin
                            if (!in_item_reg.phase_carried || !in_item_reg.phase_present) begin
                                err = ERR_UNPHASED;
                            end else if (in_item_reg.phase_info) begin
                                res.hap_first = 1'b1;
                            end else begin
                                res.hap_second = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                    // Both dosage modes decode the same way.
                    if (in_item_reg.dosage_given) begin
                        if (used_reg >= in_item_reg.dosage_count) begin
                            err = ERR_BITMAP;
                        end else begin
                            used_next = used_reg + DCOUNT_W'(1);
                            if (in_item_reg.dosage_value == DOSAGE_NA) begin
                                res.missing = 1'b1;
                            end else if (in_item_reg.dosage_value > DOSAGE_MAX) begin
                                err = ERR_OVER;
                            end else begin
                                res.dosage_q14 = in_item_reg.dosage_value;
                            end
                        end
                    end else if (in_item_reg.geno == GENO_NA) begin
                        res.missing = 1'b1;
                    end else begin
                        res.dosage_q14 = DOSAGE_W'({in_item_reg.geno, DOSAGE_ONE_SHIFT'(0)});
                    end
                    if (err == ERR_NONE && last && used_next != in_item_reg.dosage_count) begin
                        err = ERR_VALUES;
                    end
                end
            endcase
        end

        if (err != ERR_NONE) begin
            res.missing    = 1'b1;
            res.call       = '0;
            res.dosage_q14 = '0;
            res.hap_first  = 1'b0;
            res.hap_second = 1'b0;
        end
        res.error_code = err;

        if (last) begin
            pos_next     = '0;
            rec_err_next = ERR_NONE;
        end else begin
            pos_next     = pos_plus1[POS_W-1:0];
            rec_err_next = err;
        end
    end

    always_comb begin
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_HARDCALL;
            count_reg     <= LEN_W'(1);
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            used_reg      <= '0;
            rec_err_reg   <= ERR_NONE;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_MODE:         mode_reg  <= mode_t'(cfg_wdata[MODE_W-1:0]);
                    REG_SAMPLE_COUNT: count_reg <= cfg_wdata[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (step) begin
                pos_reg     <= pos_next;
                used_reg    <= last ? '0 : used_next;
                rec_err_reg <= rec_err_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= s_item;
        end
        if (step) begin
            out_item_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_item_reg.last_in_record;
    assign m_axis_tdata  = {out_item_reg.error_code,
                            out_item_reg.missing,
                            out_item_reg.hap_second,
                            out_item_reg.hap_first,
                            out_item_reg.dosage_q14,
                            out_item_reg.call,
                            out_item_reg.sample_index};

    `ASSERT_NEVER(a_err_not_missing, aclk, aresetn,
        out_valid_reg && out_item_reg.error_code != ERR_NONE && !out_item_reg.missing,
        "result with an error code is not marked missing")

    `ASSERT_PROP(a_latched_err_reported, aclk, aresetn,
        (step && rec_err_reg != ERR_NONE) |=> (out_item_reg.error_code == $past(rec_err_reg)),
        "latched record error not reported on a later sample")

    `ASSERT_PROP(a_record_end_clears, aclk, aresetn,
        (step && last) |=> (pos_reg == '0 && used_reg == '0 && rec_err_reg == ERR_NONE),
        "record state not cleared after the last sample")

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Genotype record decoder testbench
// Drives genotype samples into the decoder in every mode, with clean records
// and malformed ones, and checks each decoded sample against a local
// prediction of calls, dosages, haplotypes and latched record errors.
// ----------------------------------------------------------------------------
module testbench;
    import grd_pkg::*;

    localparam int unsigned TARGET_SAMPLES  = 1930;
    localparam int unsigned WATCHDOG_LIMIT  = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 64;

    // Predicts the decode of every accepted sample and checks results in order.
    class record_decode_checker;
        mode_t       mode;
        logic [16:0] sample_count;
        logic [15:0] position;
        logic [16:0] dosages_used;
        err_t        record_error;
        out_item_t   pending_decodes[$];
        int unsigned errors;
        int unsigned samples_in;
        int unsigned decodes_checked;
        int unsigned records_seen;
        int unsigned flagged;

        function new();
            mode = MODE_HARDCALL;
            sample_count = 17'd1;
            position = '0;
            dosages_used = '0;
            record_error = ERR_NONE;
            errors = 0;
            samples_in = 0;
            decodes_checked = 0;
            records_seen = 0;
            flagged = 0;
        endfunction

        function void apply_reg(cfg_reg_t idx, logic [16:0] value);
            if (idx == REG_MODE)
                mode = mode_t'(value[1:0]);
            else
                sample_count = value;
        endfunction

        function void note_sample(logic [S_TDATA_W-1:0] raw);
            in_item_t    s;
            out_item_t   r;
            int unsigned len;
            bit          fin;
            err_t        err;
            s.geno           = raw[1:0];
            s.dosage_given   = raw[2];
            s.dosage_value   = raw[18:3];
            s.dosage_count   = raw[35:19];
            s.phase_carried  = raw[36];
            s.phase_present  = raw[37];
            s.phase_info     = raw[38];
            samples_in++;

            // A zero length counts as one sample; long lengths saturate.
            len = (sample_count == 0) ? 1 : sample_count;
            if (len > RECORD_CAP)
                len = RECORD_CAP;
            fin = (position + 1 >= len);
            err = record_error;
            r = '0;
            r.sample_index = position;

            if (err == ERR_NONE) begin
                case (mode)
                    MODE_HARDCALL: begin
                        if (s.geno == GENO_NA)
                            r.missing = 1'b1;
                        else
                            r.call = s.geno;
                    end
                    MODE_HAPLOTYPE: begin
                        if (s.geno == GENO_NA) begin
                            err = ERR_MISSING;
                        end else if (s.geno == GENO_HOM_ALT) begin
                            r.hap_first = 1'b1;
                            r.hap_second = 1'b1;
                        end else if (s.geno == GENO_HET) begin
                            if (!s.phase_carried || !s.phase_present)
                                err = ERR_UNPHASED;
                            else if (s.phase_info)
                                r.hap_first = 1'b1;
                            else
                                r.hap_second = 1'b1;
                        end
                    end
                    default: begin
                        if (s.dosage_given) begin
                            if (dosages_used >= s.dosage_count) begin
                                err = ERR_BITMAP;
                            end else begin
                                dosages_used = dosages_used + 17'd1;
                                if (s.dosage_value == DOSAGE_NA)
                                    r.missing = 1'b1;
                                else if (s.dosage_value > DOSAGE_MAX)
                                    err = ERR_OVER;
                                else
                                    r.dosage_q14 = s.dosage_value;
                            end
                        end else if (s.geno == GENO_NA) begin
                            r.missing = 1'b1;
                        end else begin
                            r.dosage_q14 = 16'(s.geno) << DOSAGE_ONE_SHIFT;
                        end
                        if (err == ERR_NONE && fin && dosages_used != s.dosage_count)
                            err = ERR_VALUES;
                    end
                endcase
                record_error = err;
            end

            if (err != ERR_NONE) begin
                r.missing = 1'b1;
                r.call = '0;
                r.dosage_q14 = '0;
                r.hap_first = 1'b0;
                r.hap_second = 1'b0;
            end
            r.error_code = err;
            r.last_in_record = fin;
            pending_decodes.push_back(r);

            if (fin) begin
                position = '0;
                dosages_used = '0;
                record_error = ERR_NONE;
            end else begin
                position = position + 16'd1;
            end
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_decode(logic [M_TDATA_W-1:0] d, logic last);
            out_item_t e;
            if (pending_decodes.size() == 0) begin
                $error("result with no sample waiting: tdata %h", d);
                errors++;
            end else begin
                e = pending_decodes.pop_front();
                decodes_checked++;
                if (last)
                    records_seen++;
                if (d[39:37] != ERR_NONE)
                    flagged++;
                compare_field("sample_index", e.sample_index, d[15:0]);
                compare_field("call", e.call, d[17:16]);
                compare_field("dosage_q14", e.dosage_q14, d[33:18]);
                compare_field("hap_first", e.hap_first, d[34]);
                compare_field("hap_second", e.hap_second, d[35]);
                compare_field("missing", e.missing, d[36]);
                compare_field("error_code", e.error_code, d[39:37]);
                compare_field("last_in_record", e.last_in_record, last);
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // geno, dosage_given, dosage_value, dosage_count, phase_carried,
    // phase_present, phase_info, zero pad (from bit 0 up)
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // sample_index, call, dosage_q14, hap_first, hap_second, missing,
    // error_code (from bit 0 up)
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;

    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    bit          hold_off_req = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned reg_writes = 0;

    record_decode_checker decoder_sb = new();

    genotype_record_decoder DUT (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Receiver: random stalls, plus a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Inputs are noted before results are checked, so the order of noting and
    // checking is fixed.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                decoder_sb.note_sample(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                decoder_sb.check_decode(m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic send_sample(input in_item_t it);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, it.phase_info, it.phase_present, it.phase_carried,
                         it.dosage_count, it.dosage_value, it.dosage_given, it.geno};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (decoder_sb.pending_decodes.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [16:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        decoder_sb.apply_reg(idx, value);
        reg_writes++;
        @(posedge aclk);
    endtask

    function automatic in_item_t sample_of(logic [1:0] g, bit dp, logic [15:0] dv,
                                           logic [16:0] dc, bit ps, bit pp, bit pi);
        in_item_t s;
        s.geno = g;
        s.dosage_given = dp;
        s.dosage_value = dv;
        s.dosage_count = dc;
        s.phase_carried = ps;
        s.phase_present = pp;
        s.phase_info = pi;
        return s;
    endfunction

    function automatic in_item_t random_sample(mode_t m, bit clean);
        in_item_t s;
        s.geno = 2'($urandom_range(0, 3));
        s.dosage_given = 1'($urandom_range(0, 1));
        s.dosage_count = '0;
        s.phase_carried = 1'($urandom_range(0, 1));
        s.phase_present = 1'($urandom_range(0, 1));
        s.phase_info = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
            0: s.dosage_value = '0;
            1: s.dosage_value = DOSAGE_MAX;
            2: s.dosage_value = DOSAGE_NA;
            3: s.dosage_value = clean ? 16'($urandom_range(0, 32768))
                                      : 16'($urandom_range(32769, 65534));
            default: s.dosage_value = clean ? 16'($urandom_range(0, 32768))
                                            : 16'($urandom());
        endcase
        // A clean haplotype record has no missing calls and only phased hets.
        if (clean && m == MODE_HAPLOTYPE) begin
            s.geno = 2'($urandom_range(0, 2));
            s.phase_carried = 1'b1;
            if (s.geno == GENO_HET)
                s.phase_present = 1'b1;
        end
        return s;
    endfunction

    // A clean record declares exactly as many dosages as it carries.
    task automatic send_record(input int unsigned len, input bit clean);
        in_item_t    rec[$];
        in_item_t    s;
        int unsigned present;
        logic [16:0] dcnt;
        present = 0;
        for (int i = 0; i < len; i++) begin
            s = random_sample(decoder_sb.mode, clean);
            rec.push_back(s);
            if (s.dosage_given)
                present++;
        end
        dcnt = 17'(present);
        if (!clean) begin
            case ($urandom_range(0, 3))
                0: dcnt = 17'(present + 1);
                1: dcnt = (present > 0) ? 17'(present - 1) : 17'd1;
                2: dcnt = 17'($urandom_range(0, 131071));
                default: dcnt = 17'(present);
            endcase
        end
        foreach (rec[i]) begin
            s = rec[i];
            s.dosage_count = dcnt;
            if (!clean && $urandom_range(0, 9) == 0)
                s.dosage_count = 17'($urandom_range(0, 131071));
            send_sample(s);
        end
    endtask

    initial begin
        int unsigned phase;
        int unsigned len;
        logic [16:0] len_reg;
        mode_t       m;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Hardcall: every genotype code.
        write_reg(REG_MODE, 17'(MODE_HARDCALL));
        write_reg(REG_SAMPLE_COUNT, 17'd4);
        send_sample(sample_of(GENO_HOM_REF, 1'b0, 16'd0, 17'd0, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_HET, 1'b1, 16'hFFFF, 17'h1FFFF, 1'b1, 1'b1, 1'b1));
        send_sample(sample_of(GENO_HOM_ALT, 1'b0, 16'd0, 17'd0, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_NA, 1'b0, 16'd0, 17'd0, 1'b0, 1'b0, 1'b0));

        // Dosage: explicit extremes, a missing dosage and shifted genotypes.
        write_reg(REG_MODE, 17'(MODE_DOSAGE));
        write_reg(REG_SAMPLE_COUNT, 17'd5);
        send_sample(sample_of(GENO_HET, 1'b1, 16'd0, 17'd3, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_HET, 1'b1, DOSAGE_MAX, 17'd3, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_HET, 1'b1, DOSAGE_NA, 17'd3, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_HOM_ALT, 1'b0, 16'd7, 17'd3, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_NA, 1'b0, 16'd7, 17'd3, 1'b0, 1'b0, 1'b0));

        // Dosage errors: over two (then latched), too many values, too few.
        write_reg(REG_MODE, 17'(MODE_DOSAGE_F64));
        write_reg(REG_SAMPLE_COUNT, 17'd2);
        send_sample(sample_of(GENO_HET, 1'b1, 16'd32769, 17'd1, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_HET, 1'b0, 16'd0, 17'd1, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_HET, 1'b1, 16'd100, 17'd0, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_HOM_REF, 1'b0, 16'd0, 17'd0, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_HET, 1'b1, 16'd16384, 17'd2, 1'b0, 1'b0, 1'b0));
        send_sample(sample_of(GENO_HET, 1'b0, 16'd0, 17'd2, 1'b0, 1'b0, 1'b0));

        // Haplotype: both phases, then an unphased het and a missing call.
        write_reg(REG_MODE, 17'(MODE_HAPLOTYPE));
        write_reg(REG_SAMPLE_COUNT, 17'd4);
        send_sample(sample_of(GENO_HOM_REF, 1'b1, 16'd5, 17'd0, 1'b1, 1'b1, 1'b0));
        send_sample(sample_of(GENO_HOM_ALT, 1'b0, 16'd0, 17'd0, 1'b1, 1'b1, 1'b0));
        send_sample(sample_of(GENO_HET, 1'b0, 16'd0, 17'd0, 1'b1, 1'b1, 1'b1));
        send_sample(sample_of(GENO_HET, 1'b0, 16'd0, 17'd0, 1'b1, 1'b1, 1'b0));
        write_reg(REG_SAMPLE_COUNT, 17'd2);
        send_sample(sample_of(GENO_HET, 1'b0, 16'd0, 17'd0, 1'b1, 1'b0, 1'b1));
        send_sample(sample_of(GENO_HOM_REF, 1'b0, 16'd0, 17'd0, 1'b1, 1'b1, 1'b0));
        send_sample(sample_of(GENO_NA, 1'b0, 16'd0, 17'd0, 1'b1, 1'b1, 1'b0));
        send_sample(sample_of(GENO_HOM_ALT, 1'b0, 16'd0, 17'd0, 1'b1, 1'b1, 1'b0));

        // Saturated record length, then mode and length changed mid record,
        // then a zero length that counts as one.
        write_reg(REG_SAMPLE_COUNT, 17'd65536);
        write_reg(REG_MODE, 17'(MODE_HARDCALL));
        write_reg(REG_SAMPLE_COUNT, 17'h1FFFF);
        send_sample(sample_of(GENO_HOM_ALT, 1'b0, 16'd0, 17'd1, 1'b0, 1'b0, 1'b0));
        write_reg(REG_MODE, 17'(MODE_DOSAGE));
        send_sample(sample_of(GENO_HET, 1'b1, 16'd8192, 17'd1, 1'b0, 1'b0, 1'b0));
        write_reg(REG_SAMPLE_COUNT, 17'd2);
        send_sample(sample_of(GENO_HET, 1'b0, 16'd0, 17'd1, 1'b0, 1'b0, 1'b0));
        write_reg(REG_SAMPLE_COUNT, 17'd0);
        send_sample(sample_of(GENO_HOM_REF, 1'b0, 16'd0, 17'd0, 1'b0, 1'b0, 1'b0));

        // Random phases: each picks a mode, a record length and an idling
        // profile, and sends whole records, most of them well formed.
        phase = 0;
        while (decoder_sb.samples_in < TARGET_SAMPLES) begin
            case (phase % 4)
                0: begin src_idle_pct = 0; sink_stall_pct = 0; end
                1: begin src_idle_pct = 70; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 70; end
                default: begin src_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            m = mode_t'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0: len_reg = 17'd0;
                1: len_reg = 17'($urandom_range(20, 80));
                default: len_reg = 17'($urandom_range(1, 10));
            endcase
            write_reg(REG_MODE, 17'(m));
            write_reg(REG_SAMPLE_COUNT, len_reg);
            len = (len_reg == 0) ? 1 : len_reg;
            // Hold the receiver off while items keep coming, so the block
            // fills and stalls its input.
            if (phase % 8 == 4)
                hold_off_req = 1'b1;
            repeat (60 / len + 1)
                send_record(len, $urandom_range(0, 99) < 75);
            drain_results();
            phase++;
        end
        drain_results();

        $display("Checked %0d decoded samples in %0d records over %0d register writes.",
                 decoder_sb.decodes_checked, decoder_sb.records_seen, reg_writes);
        $display("All four modes ran under four idling profiles; %0d results had an error.",
                 decoder_sb.flagged);
        if (decoder_sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[genotype_record_decoder.f]
+incdir+hdl
hdl/grd_pkg.sv
hdl/genotype_record_decoder.sv
dv/testbench.sv
